// ----- rtl/lmep_pkg.sv -----
// Package for the lane marking edge pairer.
// Holds field widths, register indexes and the result struct; no dependencies.
`timescale 1ns / 1ps

package lmep_pkg;

  localparam int ROW_PIXELS  = 2048;
  localparam int COL_W       = $clog2(ROW_PIXELS + 1);
  localparam int PIXEL_W     = 8;
  localparam int SCALE_W     = 6;
  localparam int MARK_COL_W  = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int WIN_W       = CFG_DATA_W + SCALE_W;

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_WIDTH     = 1'd1;

  localparam logic [CFG_DATA_W-1:0] EDGE_THRESHOLD_RESET = 8'd50;
  localparam logic [CFG_DATA_W-1:0] PAIR_WIDTH_RESET     = 8'd50;

  // Windows this short are widened by a fixed margin.
  localparam logic [WIN_W-1:0] SHORT_WINDOW_MAX = WIN_W'(3);
  localparam logic [WIN_W-1:0] SHORT_WINDOW_ADD = WIN_W'(2);

  typedef struct packed {
    logic                  found;
    logic [MARK_COL_W-1:0] column;
  } mark_t;

endpackage

// ----- rtl/lmep_pixel_if.sv -----
// Pixel input channel: valid/ready handshake with the pixel payload.
// Depends on lmep_pkg.
`timescale 1ns / 1ps

interface lmep_pixel_if import lmep_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               row_start;
  logic [SCALE_W-1:0] row_scale;

  modport source (output valid, pixel, row_start, row_scale, input ready);
  modport sink (input valid, pixel, row_start, row_scale, output ready);
endinterface

// ----- rtl/lmep_mark_if.sv -----
// Result channel: valid/ready handshake with the marking flag and column.
// Depends on lmep_pkg.
`timescale 1ns / 1ps

interface lmep_mark_if import lmep_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  mark_found;
  logic [MARK_COL_W-1:0] mark_column;

  modport source (output valid, mark_found, mark_column, input ready);
  modport sink (input valid, mark_found, mark_column, output ready);
endinterface

// ----- rtl/lmep_cfg_if.sv -----
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on lmep_pkg.
`timescale 1ns / 1ps

interface lmep_cfg_if import lmep_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/lmep_out_skid.sv -----
// Output register with a skid stage for the result channel.
// Depends on lmep_pkg and lmep_mark_if.
`timescale 1ns / 1ps

module lmep_out_skid import lmep_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  mark_t         in_data,
  output logic          in_ready,
  lmep_mark_if.source   mark
);

  logic  out_valid;
  mark_t out_data;
  logic  skid_valid;
  mark_t skid_data;

  // The skid stage only fills when the output register is stalled, so the
  // producer can always finish one more transaction after ready drops.
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || mark.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || mark.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

  assign mark.valid       = out_valid;
  assign mark.mark_found  = out_data.found;
  assign mark.mark_column = out_data.column;

endmodule

// ----- rtl/lane_marking_edge_pairer.sv -----
// Top level of the lane marking edge pairer: gradient, edge pairing and config.
// Depends on lmep_pkg, the channel interfaces and lmep_out_skid.
`timescale 1ns / 1ps

// The block takes one gray pixel per transaction on the pixel channel, with
// row_start set on the first pixel of each row and row_scale sampled there.
// Every pixel produces exactly one transaction on the mark channel, carrying
// mark_found and the midpoint column of a rise/fall edge pair.
// The cfg channel writes edge_threshold (index 0) and pair_width (index 1);
// it is always ready, and pair_width takes effect at the next row start.
// The result is registered in the output stage. Throughput is one pixel per
// cycle while the output stage has room: the edge test, window counter and the
// row-start multiply all complete combinationally in the accept cycle.
// A two-entry output stage (register plus skid) lets one more pixel be taken
// after the receiver stalls; pixel ready then drops until the skid entry empties.
// Synchronous reset clears the pixel history, column and window state,
// loads both registers with 50, and empties the output stage.
module lane_marking_edge_pairer import lmep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lmep_pixel_if.sink  pix,
  lmep_mark_if.source mark,
  lmep_cfg_if.sink    cfg
);

  logic [CFG_DATA_W-1:0] edge_threshold;
  logic [CFG_DATA_W-1:0] pair_width;
  logic [PIXEL_W-1:0]    prev0;
  logic [PIXEL_W-1:0]    prev1;
  logic [COL_W-1:0]      column_count;
  logic [WIN_W-1:0]      row_window;
  logic [WIN_W-1:0]      window_count;
  logic [COL_W-1:0]      rise_column;

  logic [COL_W-1:0]      column_count_next;
  logic [WIN_W-1:0]      row_window_next;
  logic [WIN_W-1:0]      window_count_next;
  logic [COL_W-1:0]      rise_column_next;

  logic                  accept;
  logic                  skid_ready;
  logic [WIN_W-1:0]      product;
  logic [COL_W-1:0]      col_eff;
  logic [WIN_W-1:0]      win_eff;
  logic                  grad_ok;
  logic                  is_fall;
  logic                  is_rise;
  logic [COL_W-1:0]      center;
  logic [COL_W:0]        mid_sum;
  mark_t                 result;

  assign pix.ready = skid_ready;
  assign accept    = pix.valid && skid_ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= EDGE_THRESHOLD_RESET;
      pair_width     <= PAIR_WIDTH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_EDGE_THRESHOLD: edge_threshold <= cfg.data;
        REG_PAIR_WIDTH:     pair_width     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    product = WIN_W'(pair_width) * WIN_W'(pix.row_scale);
    if (product <= SHORT_WINDOW_MAX) begin
      product = product + SHORT_WINDOW_ADD;
    end

    col_eff = pix.row_start ? '0 : column_count;
    win_eff = pix.row_start ? '0 : window_count;
    row_window_next = pix.row_start ? product : row_window;

    grad_ok = (col_eff >= COL_W'(2)) && (col_eff < COL_W'(ROW_PIXELS));
    center  = col_eff - COL_W'(1);
    is_fall = {1'b0, prev1} > ({1'b0, pix.pixel} + {1'b0, edge_threshold});
    is_rise = {1'b0, pix.pixel} > ({1'b0, prev1} + {1'b0, edge_threshold});
    mid_sum = {1'b0, rise_column} + {1'b0, center};

    result            = '0;
    window_count_next = win_eff;
    rise_column_next  = rise_column;
    if (grad_ok) begin
      priority if (is_fall) begin
        if (win_eff != '0) begin
          result.found      = 1'b1;
          result.column     = mid_sum[MARK_COL_W:1];
          window_count_next = '0;
        end
      end else if (is_rise) begin
        rise_column_next  = center;
        window_count_next = row_window_next;
      end else if (win_eff != '0) begin
        window_count_next = win_eff - WIN_W'(1);
      end
    end

    column_count_next = (col_eff < COL_W'(ROW_PIXELS)) ? col_eff + COL_W'(1) : col_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev0        <= '0;
      prev1        <= '0;
      column_count <= '0;
      row_window   <= '0;
      window_count <= '0;
      rise_column  <= '0;
    end else if (accept) begin
      prev0        <= pix.pixel;
      prev1        <= prev0;
      column_count <= column_count_next;
      row_window   <= row_window_next;
      window_count <= window_count_next;
      rise_column  <= rise_column_next;
    end
  end

  lmep_out_skid u_out_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_data  (result),
    .in_ready (skid_ready),
    .mark     (mark)
  );

endmodule

// ----- verif/testbench.sv -----
// Testbench for lane_marking_edge_pairer: drives pixel rows and register writes, predicts
// every mark transaction in a small scoreboard class and checks it field by field.
// Depends on lmep_pkg, the pixel, mark and cfg channel interfaces and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import lmep_pkg::*;

  localparam int HOLDOFF_CYCLES = 80;
  localparam int CYCLE_LIMIT    = 400000;

  class edge_pair_scoreboard;
    bit [CFG_DATA_W-1:0] threshold;
    bit [CFG_DATA_W-1:0] base_width;
    bit [PIXEL_W-1:0]    history[2];
    bit [COL_W-1:0]      column;
    bit [WIN_W-1:0]      row_window;
    bit [WIN_W-1:0]      window_left;
    bit [MARK_COL_W-1:0] rise_column;
    mark_t               expected_marks[$];
    int                  errors;

    function new();
      threshold   = EDGE_THRESHOLD_RESET;
      base_width  = PAIR_WIDTH_RESET;
      history[0]  = '0;
      history[1]  = '0;
      column      = '0;
      row_window  = '0;
      window_left = '0;
      rise_column = '0;
      errors      = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] index, bit [CFG_DATA_W-1:0] data);
      case (index)
        REG_EDGE_THRESHOLD: threshold = data;
        REG_PAIR_WIDTH: base_width = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(bit [PIXEL_W-1:0] px, bit start, bit [SCALE_W-1:0] scale);
      int    width;
      int    gradient;
      int    center;
      mark_t result;
      result = '0;
      if (start) begin
        width = int'(base_width) * int'(scale);
        if (width <= int'(SHORT_WINDOW_MAX)) begin
          width += int'(SHORT_WINDOW_ADD);
        end
        row_window  = WIN_W'(width);
        window_left = '0;
        column      = '0;
      end
      // The gradient is centered on the previous column.
      if (column >= 2 && column < ROW_PIXELS) begin
        gradient = int'(history[1]) - int'(px);
        if (gradient > int'(threshold)) begin
          if (window_left != 0) begin
            center        = (int'(rise_column) + int'(column) - 1) / 2;
            result.found  = 1'b1;
            result.column = MARK_COL_W'(center);
            window_left   = '0;
          end
        end else if (gradient < -int'(threshold)) begin
          rise_column = MARK_COL_W'(column - 1'b1);
          window_left = row_window;
        end else if (window_left != 0) begin
          window_left = window_left - 1'b1;
        end
      end
      history[1] = history[0];
      history[0] = px;
      if (column < ROW_PIXELS) begin
        column = column + 1'b1;
      end
      expected_marks.push_back(result);
    endfunction

    function void check_mark(bit found, bit [MARK_COL_W-1:0] mark_col);
      mark_t want;
      if (expected_marks.size() == 0) begin
        $display("%0t: unexpected mark transaction, found %0d column %0d",
                 $time, found, mark_col);
        errors++;
        return;
      end
      want = expected_marks.pop_front();
      if (found != want.found) begin
        $display("%0t: mark_found expected %0d actual %0d", $time, want.found, found);
        errors++;
      end
      if (mark_col != want.column) begin
        $display("%0t: mark_column expected %0d actual %0d", $time, want.column, mark_col);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   hold_requests = 0;
  int   cycle_count   = 0;
  int   pixels_sent   = 0;

  edge_pair_scoreboard pairs;

  lmep_pixel_if pix_ch ();
  lmep_mark_if  mark_ch ();
  lmep_cfg_if   cfg_ch ();

  lane_marking_edge_pairer uut (
    .clk  (clk),
    .rst  (rst),
    .pix  (pix_ch),
    .mark (mark_ch),
    .cfg  (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver serves each hold-off request by counting its own stall cycles.
  initial begin : mark_receiver
    int holdoff_left;
    int holds_served;
    holdoff_left = 0;
    holds_served = 0;
    mark_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        holds_served++;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        mark_ch.ready <= 1'b0;
      end else begin
        mark_ch.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && mark_ch.valid && mark_ch.ready) begin
      pairs.check_mark(mark_ch.mark_found, mark_ch.mark_column);
    end
  end

  task automatic send_pixel(input bit [PIXEL_W-1:0] px, input bit start,
                            input bit [SCALE_W-1:0] scale);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid     <= 1'b1;
    pix_ch.pixel     <= px;
    pix_ch.row_start <= start;
    pix_ch.row_scale <= scale;
    do @(posedge clk); while (!pix_ch.ready);
    pairs.note_pixel(px, start, scale);
    pixels_sent++;
  endtask

  task automatic drain_marks();
    pix_ch.valid <= 1'b0;
    while (pairs.expected_marks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_registers(input bit [CFG_DATA_W-1:0] thr,
                               input bit [CFG_DATA_W-1:0] width);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_EDGE_THRESHOLD;
    cfg_ch.data  <= thr;
    do @(posedge clk); while (!cfg_ch.ready);
    pairs.write_reg(REG_EDGE_THRESHOLD, thr);
    cfg_ch.index <= REG_PAIR_WIDTH;
    cfg_ch.data  <= width;
    do @(posedge clk); while (!cfg_ch.ready);
    pairs.write_reg(REG_PAIR_WIDTH, width);
    cfg_ch.valid <= 1'b0;
  endtask

  // Well-formed rows are a dark road with bright stripes of random length; the
  // rest is random pixels with stray row starts.
  task automatic send_row(input int length, input bit with_start, input bit well_formed);
    bit [PIXEL_W-1:0] low_level;
    bit [PIXEL_W-1:0] high_level;
    bit [PIXEL_W-1:0] px;
    bit [SCALE_W-1:0] scale;
    bit               start;
    int               stripe_left;
    low_level   = PIXEL_W'($urandom_range(80, 0));
    high_level  = PIXEL_W'($urandom_range(255, int'(low_level)));
    if ($urandom_range(3, 0) == 0) begin
      scale = SCALE_W'($urandom_range(63, 0));
    end else begin
      scale = SCALE_W'($urandom_range(4, 0));
    end
    stripe_left = 0;
    for (int c = 0; c < length; c++) begin
      start = with_start && (c == 0);
      if (well_formed) begin
        if (stripe_left == 0 && $urandom_range(7, 0) == 0) begin
          stripe_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 1)
                                                    : $urandom_range(8, 1);
        end
        px = (stripe_left > 0) ? high_level : low_level;
        if (stripe_left > 0) begin
          stripe_left--;
        end
        if ($urandom_range(9, 0) == 0) begin
          px = px ^ PIXEL_W'($urandom_range(3, 0));
        end
      end else begin
        px    = PIXEL_W'($urandom_range(255, 0));
        start = start || ($urandom_range(15, 0) == 0);
      end
      send_pixel(px, start, start ? scale : SCALE_W'($urandom_range(63, 0)));
    end
  endtask

  task automatic run_segment(input int idle_mode, input bit [CFG_DATA_W-1:0] thr,
                             input bit [CFG_DATA_W-1:0] width, input int items,
                             input bit squeeze, input bit long_row);
    int target;
    drain_marks();
    set_registers(thr, width);
    case (idle_mode)
      0: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      1: begin
        src_idle_pct  = 48;
        snk_stall_pct = 0;
      end
      2: begin
        src_idle_pct  = 0;
        snk_stall_pct = 48;
      end
      default: begin
        src_idle_pct  = 19;
        snk_stall_pct = 19;
      end
    endcase
    if (squeeze) begin
      hold_requests++;
    end
    target = pixels_sent + items;
    // The row in progress goes on under the new registers.
    send_row($urandom_range(12, 1), 1'b0, 1'b1);
    if (long_row) begin
      send_row(ROW_PIXELS + 12, 1'b1, 1'b1);
    end
    while (pixels_sent < target) begin
      send_row(($urandom_range(9, 0) == 0) ? $urandom_range(120, 1) : $urandom_range(40, 1),
               1'b1, $urandom_range(4, 0) != 0);
    end
  endtask

  initial begin
    rst              <= 1'b1;
    pix_ch.valid     <= 1'b0;
    pix_ch.pixel     <= '0;
    pix_ch.row_start <= 1'b0;
    pix_ch.row_scale <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_EDGE_THRESHOLD;
    cfg_ch.data      <= '0;
    pairs = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Edges before the first row start never open a window.
    send_pixel(8'd0, 1'b0, 6'd0);
    send_pixel(8'd0, 1'b0, 6'd0);
    send_pixel(8'd200, 1'b0, 6'd0);
    send_pixel(8'd200, 1'b0, 6'd0);
    send_pixel(8'd0, 1'b0, 6'd0);
    send_pixel(8'd0, 1'b0, 6'd0);
    // A stripe inside the window, then a fall with the window already closed.
    send_pixel(8'd10, 1'b1, 6'd1);
    send_pixel(8'd10, 1'b0, 6'd0);
    send_pixel(8'd255, 1'b0, 6'd0);
    send_pixel(8'd255, 1'b0, 6'd0);
    send_pixel(8'd0, 1'b0, 6'd0);
    send_pixel(8'd0, 1'b0, 6'd0);
    // Scale zero gives the short window of two, which runs out before the fall.
    send_pixel(8'd0, 1'b1, 6'd0);
    send_pixel(8'd0, 1'b0, 6'd0);
    send_pixel(8'd255, 1'b0, 6'd0);
    send_pixel(8'd255, 1'b0, 6'd0);
    send_pixel(8'd255, 1'b0, 6'd0);
    send_pixel(8'd255, 1'b0, 6'd0);
    send_pixel(8'd0, 1'b0, 6'd0);
    send_pixel(8'd255, 1'b1, 6'd63);
    send_pixel(8'd0, 1'b0, 6'd0);
    send_pixel(8'd0, 1'b0, 6'd0);

    run_segment(0, 8'd50, 8'd50, 150, 1'b1, 1'b0);
    run_segment(1, 8'd0, 8'd0, 150, 1'b0, 1'b0);
    run_segment(2, 8'd255, 8'd255, 120, 1'b0, 1'b0);
    run_segment(3, 8'd30, 8'd1, 150, 1'b0, 1'b0);
    run_segment(0, CFG_DATA_W'($urandom_range(255, 0)), CFG_DATA_W'($urandom_range(8, 0)),
                150, 1'b0, 1'b0);
    run_segment(2, CFG_DATA_W'($urandom_range(255, 0)), CFG_DATA_W'($urandom_range(255, 0)),
                150, 1'b0, 1'b0);
    run_segment(1, 8'd40, 8'd3, 100, 1'b1, 1'b0);
    run_segment(3, 8'd60, 8'd2, 20, 1'b0, 1'b1);

    drain_marks();
    repeat (10) @(posedge clk);
    if (pairs.errors == 0 && pairs.expected_marks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
